// ----- hw/rtl/sto_pkg.sv -----
`default_nettype none
package sto_pkg;

    localparam int RANK       = 4;
    localparam int OPERANDS   = 2;
    localparam int REG_DIMS   = 4;
    localparam int MAX_OPS    = 2;
    localparam int OPSEL_W    = $clog2(MAX_OPS);
    localparam int EXT_W      = 16;
    localparam int STR_W      = 16;
    localparam int IDX_W      = 32;
    localparam int OP_W       = 2;
    localparam int OFS_W      = 48;
    localparam int STAT_W     = 2;
    localparam int PROD_W     = EXT_W + STR_W;
    localparam int CFG_W      = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int DIV_BITS   = 4;
    localparam int DIV_STAGES = IDX_W / DIV_BITS;
    localparam int DIM_STAGES = DIV_STAGES + 2;
    localparam int NSTG       = (RANK - 1) * DIM_STAGES + 2;

    localparam int S_TDATA_W  = ((OP_W + IDX_W + 7) / 8) * 8;
    localparam int M_TDATA_W  = ((OFS_W + STAT_W + 7) / 8) * 8;

    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_BAD_OP  = 2'd1;
    localparam logic [STAT_W-1:0] ST_BAD_IDX = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_STR_BASE = CFG_IDX_W'(REG_DIMS);
    localparam logic [CFG_IDX_W-1:0] CFG_END      = CFG_IDX_W'(REG_DIMS + MAX_OPS);

    typedef logic [REG_DIMS-1:0][EXT_W-1:0] t_ext_arr;
    typedef logic [MAX_OPS-1:0][CFG_W-1:0]  t_str_arr;

    typedef struct packed {
        logic              op_bad;
        logic              bad;
        logic [OP_W-1:0]   op;
        logic [IDX_W-1:0]  q;
        logic [EXT_W-1:0]  rem;
        logic [PROD_W-1:0] prod;
        logic [OFS_W-1:0]  acc;
    } t_item;

    function automatic logic [EXT_W-1:0] dim_ext(input t_ext_arr ext, input int d);
        if (d < REG_DIMS) begin
            return ext[d];
        end
        return EXT_W'(1);
    endfunction

    function automatic logic [STR_W-1:0] dim_stride(input t_str_arr str,
                                                    input logic [OP_W-1:0] op,
                                                    input int d);
        if (d >= REG_DIMS || int'(op) >= MAX_OPS) begin
            return '0;
        end
        return str[op[OPSEL_W-1:0]][STR_W*(REG_DIMS-1-d) +: STR_W];
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/sto_div_stage.sv -----
`default_nettype none
module sto_div_stage
    import sto_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire t_item            i_item,
    input  wire logic [EXT_W-1:0] i_divisor,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output t_item                 o_item
);
    logic  r_v;
    t_item r_item;
    t_item n_item;

    // Restoring division, DIV_BITS quotient bits per stage, in place in q.
    always_comb begin
        logic [EXT_W:0] rr;
        n_item = i_item;
        for (int b = 0; b < DIV_BITS; b++) begin
            rr = {n_item.rem, n_item.q[IDX_W-1]};
            n_item.q = {n_item.q[IDX_W-2:0], 1'b0};
            if (rr >= {1'b0, i_divisor}) begin
                rr = rr - {1'b0, i_divisor};
                n_item.q[0] = 1'b1;
            end
            n_item.rem = rr[EXT_W-1:0];
        end
    end

    assign o_ready = !r_v || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_v;
    assign o_item  = r_item;
endmodule
`default_nettype wire

// ----- hw/rtl/sto_mul_stage.sv -----
`default_nettype none
module sto_mul_stage
    import sto_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire t_item            i_item,
    input  wire logic [EXT_W-1:0] i_coord,
    input  wire logic             i_range_err,
    input  wire logic [STR_W-1:0] i_stride,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output t_item                 o_item
);
    logic  r_v;
    t_item r_item;
    t_item n_item;

    always_comb begin
        n_item      = i_item;
        n_item.prod = i_coord * i_stride;
        n_item.rem  = '0;
        n_item.bad  = i_item.bad | i_range_err;
    end

    assign o_ready = !r_v || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_v;
    assign o_item  = r_item;
endmodule
`default_nettype wire

// ----- hw/rtl/sto_acc_stage.sv -----
`default_nettype none
module sto_acc_stage
    import sto_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    output logic       o_ready,
    input  wire t_item i_item,
    output logic       o_valid,
    input  wire logic  i_ready,
    output t_item      o_item
);
    logic  r_v;
    t_item r_item;
    t_item n_item;

    always_comb begin
        n_item     = i_item;
        n_item.acc = i_item.acc + OFS_W'(i_item.prod);
    end

    assign o_ready = !r_v || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_v;
    assign o_item  = r_item;
endmodule
`default_nettype wire

// ----- hw/rtl/strided_tensor_offset_core.sv -----
// Throughput: one beat per cycle; each stage holds when its successor is full and stalled,
// so bubbles close up and a stalled output does not block input until the pipe is full.
// Reset (synchronous, active low) clears all stage valid bits, sets every extent to 1
// and every stride to 0.
`default_nettype none
module strided_tensor_offset_core
    import sto_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // Configuration write port: index selects extent_d0..d3, then the operand strides.
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    // Input stream.
    input  wire logic                 i_s_tvalid,
    output logic                      o_s_tready,
    // tdata, from bit 0: operand_number[1:0], flat_index[33:2], zero padding.
    input  wire logic [S_TDATA_W-1:0] i_s_tdata,
    // Output stream.
    output logic                      o_m_tvalid,
    input  wire logic                 i_m_tready,
    // tdata, from bit 0: element_offset[47:0], status[49:48], zero padding.
    output logic [M_TDATA_W-1:0]      o_m_tdata
);
    // Configuration registers. The user must change them only while the pipeline is empty;
    // the block itself does not enforce this. Every stage reads them directly.
    t_ext_arr r_ext;
    t_str_arr r_str;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < REG_DIMS; i++) begin
                r_ext[i] <= EXT_W'(1);
            end
            r_str <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx < CFG_STR_BASE) begin
                r_ext[i_cfg_idx[$clog2(REG_DIMS)-1:0]] <= i_cfg_data[EXT_W-1:0];
            end else if (i_cfg_idx < CFG_END) begin
                r_str[OPSEL_W'(i_cfg_idx - CFG_STR_BASE)] <= i_cfg_data;
            end
        end
    end

    // Stage chain: w_item[k] feeds stage k, w_item[k+1] is its registered output.
    t_item w_item  [NSTG+1];
    logic  w_valid [NSTG+1];
    logic  w_ready [NSTG+1];

    always_comb begin
        w_item[0]        = '0;
        w_item[0].op     = i_s_tdata[OP_W-1:0];
        w_item[0].q      = i_s_tdata[OP_W +: IDX_W];
        w_item[0].op_bad = (int'(i_s_tdata[OP_W-1:0]) >= OPERANDS);
    end
    assign w_valid[0] = i_s_tvalid;
    assign o_s_tready = w_ready[0];

    // Inner dimensions, innermost first: divide by the extent, the remainder is
    // the coordinate, multiply it by the stride, then add into the offset.
    // A zero extent marks the index out of range.
    for (genvar k = 0; k < RANK - 1; k++) begin : g_dim
        localparam int D    = RANK - 1 - k;
        localparam int BASE = k * DIM_STAGES;

        for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
            sto_div_stage u_div (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_valid   (w_valid[BASE+s]),
                .o_ready   (w_ready[BASE+s]),
                .i_item    (w_item[BASE+s]),
                .i_divisor (dim_ext(r_ext, D)),
                .o_valid   (w_valid[BASE+s+1]),
                .i_ready   (w_ready[BASE+s+1]),
                .o_item    (w_item[BASE+s+1])
            );
        end

        sto_mul_stage u_mul (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_valid     (w_valid[BASE+DIV_STAGES]),
            .o_ready     (w_ready[BASE+DIV_STAGES]),
            .i_item      (w_item[BASE+DIV_STAGES]),
            .i_coord     (w_item[BASE+DIV_STAGES].rem),
            .i_range_err (dim_ext(r_ext, D) == '0),
            .i_stride    (dim_stride(r_str, w_item[BASE+DIV_STAGES].op, D)),
            .o_valid     (w_valid[BASE+DIV_STAGES+1]),
            .i_ready     (w_ready[BASE+DIV_STAGES+1]),
            .o_item      (w_item[BASE+DIV_STAGES+1])
        );

        sto_acc_stage u_acc (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[BASE+DIV_STAGES+1]),
            .o_ready (w_ready[BASE+DIV_STAGES+1]),
            .i_item  (w_item[BASE+DIV_STAGES+1]),
            .o_valid (w_valid[BASE+DIM_STAGES]),
            .i_ready (w_ready[BASE+DIM_STAGES]),
            .o_item  (w_item[BASE+DIM_STAGES])
        );
    end

    // Outermost dimension: the remaining quotient is the coordinate. The index
    // lies inside the shape exactly when that quotient is below extent_d0,
    // which also covers a zero outer extent.
    localparam int LAST = (RANK - 1) * DIM_STAGES;
    logic w_outer_err;
    assign w_outer_err = w_item[LAST].q >= IDX_W'(dim_ext(r_ext, 0));

    sto_mul_stage u_mul_outer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_valid[LAST]),
        .o_ready     (w_ready[LAST]),
        .i_item      (w_item[LAST]),
        .i_coord     (w_item[LAST].q[EXT_W-1:0]),
        .i_range_err (w_outer_err),
        .i_stride    (dim_stride(r_str, w_item[LAST].op, 0)),
        .o_valid     (w_valid[LAST+1]),
        .i_ready     (w_ready[LAST+1]),
        .o_item      (w_item[LAST+1])
    );

    // The last accumulate stage is also the output register.
    sto_acc_stage u_acc_outer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_valid[LAST+1]),
        .o_ready (w_ready[LAST+1]),
        .i_item  (w_item[LAST+1]),
        .o_valid (w_valid[NSTG]),
        .i_ready (w_ready[NSTG]),
        .o_item  (w_item[NSTG])
    );

    assign w_ready[NSTG] = i_m_tready;
    assign o_m_tvalid    = w_valid[NSTG];

    // The operand check takes precedence over the index check; a failed check
    // forces the offset to zero.
    logic [STAT_W-1:0] w_status;
    logic [OFS_W-1:0]  w_offset;

    always_comb begin
        if (w_item[NSTG].op_bad) begin
            w_status = ST_BAD_OP;
        end else if (w_item[NSTG].bad) begin
            w_status = ST_BAD_IDX;
        end else begin
            w_status = ST_OK;
        end
        w_offset = (w_status == ST_OK) ? w_item[NSTG].acc : '0;
    end

    assign o_m_tdata = M_TDATA_W'({w_status, w_offset});
endmodule
`default_nettype wire

// ----- hw/rtl/sto_checker.sv -----
`default_nettype none
module sto_checker
    import sto_pkg::*;
(
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 o_s_tready,
    input wire logic                 o_m_tvalid,
    input wire logic                 i_m_tready,
    input wire logic [M_TDATA_W-1:0] o_m_tdata
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("output beat changed while stalled");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[OFS_W +: STAT_W] == ST_OK
                     || o_m_tdata[OFS_W +: STAT_W] == ST_BAD_OP
                     || o_m_tdata[OFS_W +: STAT_W] == ST_BAD_IDX))
        else $error("undefined status code");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[OFS_W +: STAT_W] != ST_OK |-> o_m_tdata[OFS_W-1:0] == '0)
        else $error("nonzero offset with error status");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid right after reset");

    a_ready_when_draining: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tready |-> o_s_tready)
        else $error("input blocked while output drains");
endmodule

bind strided_tensor_offset_core sto_checker u_sto_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
`default_nettype wire

// ----- test/testbench.sv -----
`default_nettype none
module testbench;
    import sto_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Depth of the core's stage pipeline, equal to NSTG in sto_pkg.
    localparam int PIPE_DEPTH = 32;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [OFS_W-1:0]  offset;
    } t_offset_result;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]     cfg_data;
    logic                 s_tvalid;
    logic                 s_tready;
    // tdata, from bit 0: operand_number[1:0], flat_index[33:2], zero padding.
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    // tdata, from bit 0: element_offset[47:0], status[49:48], zero padding.
    logic [M_TDATA_W-1:0] m_tdata;

    strided_tensor_offset_core u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    // Shadow copy of the registers, kept in step with every write we make.
    logic [EXT_W-1:0] shadow_extent [REG_DIMS];
    logic [CFG_W-1:0] shadow_strides [MAX_OPS];

    t_offset_result pending_offsets [$];
    int             error_count;
    int             hold_off_cycles;  // when nonzero, the receiver stalls this long
    int             rx_wait;          // idle cycles the receiver takes before the next beat

    initial clk = 1'b0;
    always #10 clk = ~clk;

    initial begin
        #20ms;
        $display("Some tests failed");
        $finish;
    end

    task automatic report_mismatch(input string what);
        error_count++;
        $display("MISMATCH at %0t: %s", $realtime, what);
    endtask

    // Splits the index innermost dimension first and sums coordinate * stride.
    function automatic t_offset_result compute_offset(input logic [OP_W-1:0] op,
                                                      input logic [IDX_W-1:0] index);
        t_offset_result r;
        longint unsigned total;
        longint unsigned rest;
        longint unsigned sum;
        longint unsigned ext;
        longint unsigned stride;
        total = 1;
        sum = 0;
        r.offset = '0;
        if (int'(op) >= OPERANDS) begin
            r.status = ST_BAD_OP;
            return r;
        end
        for (int d = 0; d < RANK; d++) total *= shadow_extent[d];
        if (longint'(index) >= total) begin
            r.status = ST_BAD_IDX;
            return r;
        end
        rest = index;
        for (int d = RANK - 1; d >= 0; d--) begin
            ext = shadow_extent[d];
            stride = shadow_strides[op][STR_W*(REG_DIMS-1-d) +: STR_W];
            sum += (rest % ext) * stride;
            rest /= ext;
        end
        r.offset = sum[OFS_W-1:0];
        r.status = ST_OK;
        return r;
    endfunction

    // Drives one write for a cycle; the caller drops the write enable afterwards.
    task automatic write_register(input int idx, input logic [CFG_W-1:0] value);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_IDX_W'(idx);
        cfg_data <= value;
        @(negedge clk);
        if (idx < REG_DIMS) shadow_extent[idx] = value[EXT_W-1:0];
        else if (idx < REG_DIMS + MAX_OPS) shadow_strides[idx-REG_DIMS] = value;
    endtask

    task automatic set_shape(input int e0, input int e1, input int e2, input int e3,
                             input logic [CFG_W-1:0] str0, input logic [CFG_W-1:0] str1);
        write_register(0, CFG_W'(e0));
        write_register(1, CFG_W'(e1));
        write_register(2, CFG_W'(e2));
        write_register(3, CFG_W'(e3));
        write_register(int'(CFG_STR_BASE), str0);
        write_register(int'(CFG_STR_BASE) + 1, str1);
        cfg_we <= 1'b0;
    endtask

    // Waits until every expected beat has come back, then lets the pipe drain.
    task automatic wait_idle();
        while (pending_offsets.size() != 0) @(negedge clk);
        repeat (PIPE_DEPTH + 4) @(negedge clk);
    endtask

    // Sends one beat, after a random gap unless no_gap is set; the expectation is queued on acceptance.
    task automatic send_index(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] index,
                              input bit no_gap = 1'b0);
        int gap;
        gap = no_gap ? 0 : ($urandom_range(0, 3) == 0 ? $urandom_range(0, 18) : 0);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'({index, op});
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        pending_offsets.insert(pending_offsets.size(), compute_offset(op, index));
        @(negedge clk);
    endtask

    task automatic end_burst();
        s_tvalid <= 1'b0;
    endtask

    // Picks an index mostly inside the valid range, sometimes just past it or anywhere.
    function automatic logic [IDX_W-1:0] pick_index();
        longint unsigned total;
        total = 1;
        for (int d = 0; d < RANK; d++) total *= shadow_extent[d];
        case ($urandom_range(0, 9))
            0: return $urandom();
            1: return (total > 0 && total <= 64'hFFFF_FFFF) ? IDX_W'(total) : $urandom();
            2: return (total > 0 && total <= 64'h1_0000_0000) ? IDX_W'(total - 1) : '0;
            default: return (total == 0) ? $urandom() :
                            IDX_W'({$urandom(), $urandom()} % total);
        endcase
    endfunction

    function automatic logic [OP_W-1:0] pick_operand();
        return ($urandom_range(0, 7) == 0) ? OP_W'($urandom_range(2, 3))
                                           : OP_W'($urandom_range(0, 1));
    endfunction

    // Receiver: a random wait before each beat, plus a long hold-off when requested.
    always @(negedge clk) begin
        if (!rst_n) begin
            m_tready <= 1'b0;
            rx_wait = 0;
        end else if (hold_off_cycles > 0) begin
            m_tready <= 1'b0;
            hold_off_cycles <= hold_off_cycles - 1;
        end else if (rx_wait > 0) begin
            m_tready <= 1'b0;
            rx_wait--;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Checker: every accepted output beat against the oldest expectation.
    always @(posedge clk) begin
        t_offset_result got;
        t_offset_result want;
        if (rst_n && m_tvalid && m_tready) begin
            rx_wait = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : 0;
            got = m_tdata[OFS_W+STAT_W-1:0];
            if (pending_offsets.size() == 0) begin
                report_mismatch("output beat with nothing expected");
            end else begin
                want = pending_offsets.pop_front();
                if (got.status !== want.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              got.status, want.status));
                if (got.offset !== want.offset)
                    report_mismatch($sformatf("offset %0h, expected %0h",
                                              got.offset, want.offset));
            end
        end
    end

    // Reset values: every extent 1, every stride 0, so index 0 is the only valid one.
    task automatic test_reset_state();
        for (int d = 0; d < REG_DIMS; d++) shadow_extent[d] = 1;
        for (int o = 0; o < MAX_OPS; o++) shadow_strides[o] = '0;
        send_index(0, 0);
        send_index(1, 0);
        send_index(0, 1);
        send_index(1, 32'hFFFF_FFFF);
        end_burst();
        wait_idle();
    endtask

    // Field extremes, both operands, bad operands and the bad index boundary.
    task automatic test_directed();
        set_shape(3, 5, 7, 11, 64'h0123_4567_89AB_CDEF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_index(0, 0);
        send_index(1, 0);
        send_index(0, 1154);
        send_index(1, 1154);
        send_index(0, 1155);
        send_index(1, 32'hFFFF_FFFF);
        send_index(2, 5);
        send_index(3, 32'hFFFF_FFFF);
        send_index(1, 32'h5555_5555);
        end_burst();
        wait_idle();
        // Largest extents: product exceeds the index range, so every index is valid.
        set_shape(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                  64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0001_7FFF_AAAA);
        send_index(0, 32'hFFFF_FFFF);
        send_index(1, 32'hFFFF_FFFF);
        send_index(0, 32'hAAAA_AAAA);
        send_index(1, 32'h1234_5678);
        end_burst();
        wait_idle();
        // A zero extent makes every index out of range.
        set_shape(4, 0, 4, 4, 64'h1, 64'h2);
        send_index(0, 0);
        send_index(1, 3);
        send_index(3, 0);
        end_burst();
        wait_idle();
    endtask

    // Random shapes and strides, some with extremes, each with a burst of random indexes.
    task automatic test_random_shapes();
        int e [4];
        for (int phase = 0; phase < 12; phase++) begin
            for (int d = 0; d < 4; d++) begin
                case ($urandom_range(0, 9))
                    0: e[d] = 0;
                    1: e[d] = 16'hFFFF;
                    2: e[d] = 1;
                    default: e[d] = $urandom_range(1, 40);
                endcase
            end
            if (phase == 11) e = '{1, 1, 1, 1};
            set_shape(e[0], e[1], e[2], e[3], {$urandom(), $urandom()},
                      {$urandom(), $urandom()});
            repeat (35) send_index(pick_operand(), pick_index());
            end_burst();
            wait_idle();
        end
    endtask

    // Long receiver stall while the sender keeps offering beats back to back.
    task automatic test_back_pressure();
        set_shape(2, 3, 4, 5, 64'h0001_0002_0003_0004, 64'hFFFF_0100_0010_0001);
        hold_off_cycles = 200;
        repeat (60) send_index(pick_operand(), pick_index(), 1'b1);
        end_burst();
        wait_idle();
    endtask

    initial begin
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_idx         = '0;
        cfg_data        = '0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        error_count     = 0;
        hold_off_cycles = 0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_state();
        test_directed();
        test_back_pressure();
        test_random_shapes();

        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
`default_nettype wire

// ----- sim.f -----
hw/rtl/sto_pkg.sv
hw/rtl/sto_div_stage.sv
hw/rtl/sto_mul_stage.sv
hw/rtl/sto_acc_stage.sv
hw/rtl/strided_tensor_offset_core.sv
hw/rtl/sto_checker.sv
test/testbench.sv
